// ===== rtl/core/ecam_pkg.sv =====
`default_nettype none

package ecam_pkg;

	localparam int unsigned MAX_WINDOWS = 4;
	localparam int unsigned ADDR_W      = 48;
	localparam int unsigned RANGE_W     = 17;
	localparam int unsigned BUS_W       = 8;
	localparam int unsigned END_W       = 9;
	localparam int unsigned WIN_IDX_W   = 2;
	localparam int unsigned PAGE_SHIFT  = 20;
	localparam int unsigned PAGE_W      = ADDR_W - PAGE_SHIFT;

	// apb register map, 8 byte stride
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned PADDR_W   = REG_IDX_W + 3;
	localparam int unsigned PDATA_W   = 64;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW0_BASE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW0_RANGE = 3'd4;

	typedef struct packed {
		logic [7:0] bus_number;
		logic [4:0] slot_number;
		logic [2:0] function_number;
		logic [7:0] register_offset;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]    target_address;
		logic                 hit;
		logic [WIN_IDX_W-1:0] window_index;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/ecam_xlate.sv =====
`default_nettype none

module ecam_xlate #(
	parameter int unsigned WINDOW_COUNT = 4
) (
	input  var ecam_pkg::req_t                       req,
	input  var logic [ecam_pkg::ADDR_W-1:0]          base  [WINDOW_COUNT],
	input  var logic [ecam_pkg::RANGE_W-1:0]         range [WINDOW_COUNT],
	output ecam_pkg::rsp_t                           rsp
);

	logic [WINDOW_COUNT-1:0] in_range;
	logic [WINDOW_COUNT-1:0] is_end;

	always_comb begin
		for (int i = 0; i < WINDOW_COUNT; i++) begin
			is_end[i]   = (base[i] == '0);
			in_range[i] = (req.bus_number >= range[i][ecam_pkg::BUS_W-1:0]) &&
				({1'b0, req.bus_number} <
				 range[i][ecam_pkg::RANGE_W-1:ecam_pkg::BUS_W]);
		end
	end

	// first window that holds the bus, scan ends at a zero base
	logic                                done;
	logic                                hit;
	logic [ecam_pkg::WIN_IDX_W-1:0]      idx;
	logic [ecam_pkg::PAGE_W-1:0]         sel_page;
	logic [ecam_pkg::BUS_W-1:0]          sel_start;
	logic [ecam_pkg::BUS_W-1:0]          bus_delta;
	logic [ecam_pkg::PAGE_W-1:0]         page;

	always_comb begin
		done      = 1'b0;
		hit       = 1'b0;
		idx       = '0;
		sel_page  = '0;
		sel_start = '0;
		for (int i = 0; i < WINDOW_COUNT; i++) begin
			if (!done) begin
				if (is_end[i]) begin
					done = 1'b1;
				end else if (in_range[i]) begin
					done      = 1'b1;
					hit       = 1'b1;
					idx       = ecam_pkg::WIN_IDX_W'(i);
					sel_page  = base[i][ecam_pkg::ADDR_W-1:ecam_pkg::PAGE_SHIFT];
					sel_start = range[i][ecam_pkg::BUS_W-1:0];
				end
			end
		end
		bus_delta = req.bus_number - sel_start;
		page      = sel_page + ecam_pkg::PAGE_W'(bus_delta);

		rsp.hit          = hit;
		rsp.window_index = idx;
		if (hit) begin
			rsp.target_address = {page, req.slot_number, req.function_number,
				4'b0000, req.register_offset};
		end else begin
			rsp.target_address = '0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ecam_config_address_translator.sv =====
// ecam address translator: bus/slot/function/offset to memory address
// path: input transaction to result through the input reg, then the result reg
// throughput: one transaction per cycle without out_stall; the window lookup and one 28-bit add
//   sit between the input register and the result register
// reset (arst_n, async low): pipeline empty, all window registers zero
`default_nettype none

module ecam_config_address_translator #(
	parameter int unsigned WINDOW_COUNT = 4
) (
	input  var logic                              clk,
	input  var logic                              arst_n,

	// request channel
	input  var logic                              in_valid,
	output logic                                  in_stall,
	input  var ecam_pkg::req_t                    in_data,

	// result channel
	output logic                                  out_valid,
	input  var logic                              out_stall,
	output ecam_pkg::rsp_t                        out_data,

	// apb register port
	input  var logic                              psel,
	input  var logic                              penable,
	input  var logic                              pwrite,
	input  var logic [ecam_pkg::PADDR_W-1:0]      paddr,
	input  var logic [ecam_pkg::PDATA_W-1:0]      pwdata,
	output logic [ecam_pkg::PDATA_W-1:0]          prdata,
	output logic                                  pready
);

	// ------------------------------------------------------------------
	// window registers
	// ------------------------------------------------------------------
	logic [ecam_pkg::ADDR_W-1:0]  base_q  [WINDOW_COUNT];
	logic [ecam_pkg::RANGE_W-1:0] range_q [WINDOW_COUNT];

	logic                              cfg_wr;
	logic [ecam_pkg::REG_IDX_W-1:0]    reg_idx;
	logic                              reg_is_range;
	logic [ecam_pkg::WIN_IDX_W-1:0]    reg_win;

	assign pready       = 1'b1;
	assign cfg_wr       = psel && penable && pwrite && pready;
	assign reg_idx      = paddr[ecam_pkg::PADDR_W-1:3];
	assign reg_is_range = (reg_idx >= ecam_pkg::REG_WINDOW0_RANGE);
	// window number of the addressed register, either group
	assign reg_win      = reg_is_range
		? ecam_pkg::WIN_IDX_W'(reg_idx - ecam_pkg::REG_WINDOW0_RANGE)
		: ecam_pkg::WIN_IDX_W'(reg_idx - ecam_pkg::REG_WINDOW0_BASE);

	// writes to windows beyond WINDOW_COUNT are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < WINDOW_COUNT; w++) begin
				base_q[w]  <= '0;
				range_q[w] <= '0;
			end
		end else if (cfg_wr) begin
			for (int w = 0; w < WINDOW_COUNT; w++) begin
				if (reg_win == ecam_pkg::WIN_IDX_W'(w)) begin
					if (reg_is_range) begin
						range_q[w] <= pwdata[ecam_pkg::RANGE_W-1:0];
					end else begin
						base_q[w] <= pwdata[ecam_pkg::ADDR_W-1:0];
					end
				end
			end
		end
	end

	// read back, unimplemented windows read as zero
	always_comb begin
		prdata = '0;
		for (int w = 0; w < WINDOW_COUNT; w++) begin
			if (reg_win == ecam_pkg::WIN_IDX_W'(w)) begin
				if (reg_is_range) begin
					prdata = ecam_pkg::PDATA_W'(range_q[w]);
				end else begin
					prdata = ecam_pkg::PDATA_W'(base_q[w]);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// pipeline: input register (s1) -> lookup -> result register
	// ------------------------------------------------------------------
	logic           valid_s1;
	ecam_pkg::req_t req_s1;
	ecam_pkg::rsp_t rsp_s1;
	logic           out_valid_q;
	ecam_pkg::rsp_t out_data_q;
	logic           advance;
	logic           in_take;

	// s1 moves on whenever the result register is empty or being drained
	assign advance  = !out_valid_q || !out_stall;
	// stall only when s1 is holding a transaction that cannot move
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1 <= in_data;
		end
	end

	ecam_xlate #(
		.WINDOW_COUNT (WINDOW_COUNT)
	) u_xlate (
		.req   (req_s1),
		.base  (base_q),
		.range (range_q),
		.rsp   (rsp_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q <= rsp_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// a miss carries zero address and zero index
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.hit) |->
			(out_data.target_address == '0 && out_data.window_index == '0))
		else $error("miss result with nonzero address or index");

	// back pressure only when both stages are full and the sink stalls
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with room in the pipeline");

	// a transaction leaving s1 lands in the result register
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> out_valid_q)
		else $error("s1 transaction lost");

	// a hit names an implemented window
	a_hit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.hit) |-> (32'(out_data.window_index) < WINDOW_COUNT))
		else $error("hit on unimplemented window");

endmodule

`default_nettype wire

// ===== bench/tb_ecam_config_address_translator.sv =====
`default_nettype none

module tb_ecam_config_address_translator;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WINDOW_COUNT = 4;
	// result register plus input register, with margin
	localparam int unsigned SETTLE_CYCLES = 4;
	// ceiling on the wait for outstanding results at a drain point
	localparam int unsigned DRAIN_LIMIT = 2000;
	localparam int unsigned RANDOM_PHASES = 10;
	localparam int unsigned ITEMS_PER_PHASE = 153;

	logic                           clk = 1'b0;
	logic                           arst_n;

	logic                           in_valid;
	logic                           in_stall;
	ecam_pkg::req_t                 in_data;
	logic                           out_valid;
	logic                           out_stall;
	ecam_pkg::rsp_t                 out_data;

	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [ecam_pkg::PADDR_W-1:0]   paddr;
	logic [ecam_pkg::PDATA_W-1:0]   pwdata;
	logic [ecam_pkg::PDATA_W-1:0]   prdata;
	logic                           pready;

	// shadow copy of the window table, updated on every register write
	logic [ecam_pkg::ADDR_W-1:0]    window_base [ecam_pkg::MAX_WINDOWS];
	logic [ecam_pkg::RANGE_W-1:0]   window_range [ecam_pkg::MAX_WINDOWS];

	// translations predicted for accepted requests, oldest first
	ecam_pkg::rsp_t                 pending_translations [$];
	int unsigned                    mismatch_count = 0;

	// when set, the matching side runs without idle cycles
	bit                             tx_calm = 1'b0;
	bit                             rx_calm = 1'b0;

	ecam_config_address_translator #(
		.WINDOW_COUNT (WINDOW_COUNT)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// expected translation for one request against the shadow table
	function automatic ecam_pkg::rsp_t translate_target(input ecam_pkg::req_t access);
		ecam_pkg::rsp_t res;
		logic [7:0]     first_bus;
		logic [8:0]     end_bus;
		res = '0;
		for (int w = 0; w < WINDOW_COUNT && w < ecam_pkg::MAX_WINDOWS; w++) begin
			// a zero base ends the table, checked over all address bits
			if (window_base[w] == '0)
				return res;
			first_bus = window_range[w][7:0];
			end_bus   = window_range[w][16:8];
			// empty or inverted ranges never match, end above 256 covers all
			if (access.bus_number >= first_bus && {1'b0, access.bus_number} < end_bus) begin
				res.target_address =
					{window_base[w][ecam_pkg::ADDR_W-1:ecam_pkg::PAGE_SHIFT],
						{ecam_pkg::PAGE_SHIFT{1'b0}}}
					+ (ecam_pkg::ADDR_W'(access.bus_number - first_bus)
						<< ecam_pkg::PAGE_SHIFT)
					+ (ecam_pkg::ADDR_W'(access.slot_number) << 15)
					+ (ecam_pkg::ADDR_W'(access.function_number) << 12)
					+ ecam_pkg::ADDR_W'(access.register_offset);
				res.hit          = 1'b1;
				res.window_index = ecam_pkg::WIN_IDX_W'(w);
				return res;
			end
		end
		return res;
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s: expected %h, got %h", what, want, got);
	endtask

	// result checker: every accepted result against the oldest prediction
	always @(posedge clk) begin : check_results
		ecam_pkg::rsp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_translations.size() == 0) begin
				note_mismatch("result with nothing pending", '0, 64'(out_data));
			end else begin
				want = pending_translations.pop_front();
				if (out_data.target_address !== want.target_address)
					note_mismatch("target_address", 64'(want.target_address),
						64'(out_data.target_address));
				if (out_data.hit !== want.hit)
					note_mismatch("hit", 64'(want.hit), 64'(out_data.hit));
				if (out_data.window_index !== want.window_index)
					note_mismatch("window_index", 64'(want.window_index),
						64'(out_data.window_index));
			end
		end
	end

	// result side: random stall before taking each transaction
	initial begin : result_sink
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = rx_calm ? 0 : $urandom_range(0, 5);
			repeat (hold) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// one request transaction, predicted at the edge it is accepted
	task automatic send_access(input logic [7:0] bus, input logic [4:0] slot,
			input logic [2:0] func, input logic [7:0] offset);
		ecam_pkg::req_t access;
		int             gap;
		access.bus_number      = bus;
		access.slot_number     = slot;
		access.function_number = func;
		access.register_offset = offset;
		gap = tx_calm ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= access;
		do @(posedge clk); while (in_stall);
		pending_translations.push_back(translate_target(access));
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		for (int n = 0; n < DRAIN_LIMIT && pending_translations.size() > 0; n++)
			@(posedge clk);
		if (pending_translations.size() != 0) begin
			note_mismatch("results never arrived", 64'(pending_translations.size()), '0);
			pending_translations.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write: setup phase, then access phase until pready
	task automatic write_register(input logic [ecam_pkg::REG_IDX_W-1:0] idx,
			input logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx < ecam_pkg::REG_WINDOW0_RANGE)
			window_base[idx] = value[ecam_pkg::ADDR_W-1:0];
		else
			window_range[idx - ecam_pkg::REG_WINDOW0_RANGE] = value[ecam_pkg::RANGE_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// apb read, compared with the shadow table
	task automatic check_register(input logic [ecam_pkg::REG_IDX_W-1:0] idx);
		logic [63:0] want;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 3'b000};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx < ecam_pkg::REG_WINDOW0_RANGE)
			want = 64'(window_base[idx]);
		else
			want = 64'(window_range[idx - ecam_pkg::REG_WINDOW0_RANGE]);
		if (prdata !== want)
			note_mismatch($sformatf("register %0d readback", idx), want, prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// random window table: zero bases, low-bit-only bases, all-ones bases,
	// empty or inverted ranges and ranges running past bus 255
	task automatic load_random_windows();
		logic [ecam_pkg::ADDR_W-1:0] base;
		int                          first_bus;
		int                          end_bus;
		for (int w = 0; w < ecam_pkg::MAX_WINDOWS; w++) begin
			case ($urandom_range(0, 9))
				0: base = '0;
				1: base = ecam_pkg::ADDR_W'($urandom_range(1, 20'hFFFFF));
				2: base = '1;
				default: base = ecam_pkg::ADDR_W'({$urandom, $urandom});
			endcase
			first_bus = $urandom_range(0, 255);
			case ($urandom_range(0, 7))
				0: end_bus = $urandom_range(0, first_bus);
				1: end_bus = $urandom_range(257, 511);
				default: end_bus = $urandom_range(first_bus + 1, 256);
			endcase
			write_register(ecam_pkg::REG_WINDOW0_BASE + ecam_pkg::REG_IDX_W'(w), 64'(base));
			write_register(ecam_pkg::REG_WINDOW0_RANGE + ecam_pkg::REG_IDX_W'(w),
				64'({9'(end_bus), 8'(first_bus)}));
		end
	endtask

	// after reset the table is empty, so every access misses
	task automatic test_reset_state();
		for (int i = 0; i < 2 * ecam_pkg::MAX_WINDOWS; i++)
			check_register(ecam_pkg::REG_IDX_W'(i));
		send_access(8'd0, 5'd0, 3'd0, 8'd0);
		send_access(8'd255, 5'd31, 3'd7, 8'd255);
		send_access(8'd128, 5'd16, 3'd4, 8'd128);
		wait_for_results();
	endtask

	// one window over every bus, fields at their extremes
	task automatic test_field_extremes();
		write_register(ecam_pkg::REG_WINDOW0_BASE, 64'h0000_0012_3450_0000);
		write_register(ecam_pkg::REG_WINDOW0_RANGE, 64'({9'd256, 8'd0}));
		send_access(8'd0, 5'd0, 3'd0, 8'd0);
		send_access(8'd255, 5'd31, 3'd7, 8'd255);
		send_access(8'h55, 5'h0A, 3'd5, 8'hAA);
		send_access(8'hAA, 5'h15, 3'd2, 8'h55);
		wait_for_results();
	endtask

	// scan order, end of table, odd ranges and address wrap
	task automatic test_table_scan();
		// all-ones base on the top buses wraps past 48 bits
		write_register(ecam_pkg::REG_WINDOW0_BASE, 64'h0000_FFFF_FFFF_FFFF);
		write_register(ecam_pkg::REG_WINDOW0_RANGE, 64'({9'd256, 8'd250}));
		// base set only below bit 20: table goes on, base adds nothing
		write_register(ecam_pkg::REG_WINDOW0_BASE + 3'd1, 64'h0000_0000_0000_0001);
		write_register(ecam_pkg::REG_WINDOW0_RANGE + 3'd1, 64'({9'd20, 8'd10}));
		// empty range, start equal to end
		write_register(ecam_pkg::REG_WINDOW0_BASE + 3'd2, 64'h0000_0000_4000_0000);
		write_register(ecam_pkg::REG_WINDOW0_RANGE + 3'd2, 64'({9'd60, 8'd60}));
		// end far above 256 catches everything left over
		write_register(ecam_pkg::REG_WINDOW0_BASE + 3'd3, 64'h0000_8000_0000_0000);
		write_register(ecam_pkg::REG_WINDOW0_RANGE + 3'd3, 64'({9'd511, 8'd0}));
		send_access(8'd255, 5'd31, 3'd7, 8'd255);
		send_access(8'd250, 5'd1, 3'd1, 8'd4);
		send_access(8'd15, 5'd3, 3'd6, 8'd16);
		send_access(8'd60, 5'd0, 3'd0, 8'd0);
		send_access(8'd0, 5'd0, 3'd0, 8'd8);
		wait_for_results();

		// inverted range on window 2 falls through to window 3
		write_register(ecam_pkg::REG_WINDOW0_RANGE + 3'd2, 64'({9'd50, 8'd100}));
		send_access(8'd75, 5'd9, 3'd3, 8'd40);
		wait_for_results();

		// zero base on window 1 hides windows 2 and 3; top-valued range on window 0
		write_register(ecam_pkg::REG_WINDOW0_BASE + 3'd1, 64'h0);
		write_register(ecam_pkg::REG_WINDOW0_RANGE, 64'({9'd256, 8'd255}));
		send_access(8'd255, 5'd2, 3'd2, 8'd2);
		send_access(8'd254, 5'd2, 3'd2, 8'd2);
		send_access(8'd15, 5'd3, 3'd6, 8'd16);
		send_access(8'd0, 5'd0, 3'd0, 8'd0);
		wait_for_results();
	endtask

	// every register written with random values and read back
	task automatic test_register_readback();
		load_random_windows();
		for (int i = 0; i < 2 * ecam_pkg::MAX_WINDOWS; i++)
			check_register(ecam_pkg::REG_IDX_W'(i));
	endtask

	// random tables, most accesses aimed inside a configured window
	task automatic test_random_traffic();
		int          pick;
		int          first_bus;
		int          last_bus;
		logic [7:0]  bus;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			load_random_windows();
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// switch between idling and back-to-back stretches
				if (k % 51 == 0) begin
					tx_calm = ($urandom_range(0, 3) == 0);
					rx_calm = ($urandom_range(0, 3) == 0);
				end
				// in phase 3 the sender holds off mid-phase until the pipeline is empty
				if (phase == 3 && k == ITEMS_PER_PHASE / 2)
					wait_for_results();
				bus  = 8'($urandom_range(0, 255));
				pick = $urandom_range(0, ecam_pkg::MAX_WINDOWS);
				if (pick < ecam_pkg::MAX_WINDOWS) begin
					first_bus = window_range[pick][7:0];
					last_bus  = window_range[pick][16:8];
					if (last_bus > 256)
						last_bus = 256;
					if (last_bus > first_bus)
						bus = 8'($urandom_range(first_bus, last_bus - 1));
				end
				send_access(bus, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
					8'($urandom_range(0, 255)));
			end
			wait_for_results();
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	initial begin
		// every input known from time zero, reset held low at the start
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		for (int w = 0; w < ecam_pkg::MAX_WINDOWS; w++) begin
			window_base[w]  = '0;
			window_range[w] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_field_extremes();
		test_table_scan();
		test_register_readback();
		test_random_traffic();

		if (mismatch_count == 0) begin
			$display("PASS ecam_config_address_translator");
		end else begin
			$display("FAIL ecam_config_address_translator");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("FAIL ecam_config_address_translator");
		$finish;
	end

endmodule

`default_nettype wire
